// ----- rtl/scale3x_pixel_art_upscaler_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SCALE3X_PIXEL_ART_UPSCALER_UNIT_DEFINES_SVH
`define SCALE3X_PIXEL_ART_UPSCALER_UNIT_DEFINES_SVH

// Check on every rising edge of clk outside reset.
`define S3X_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Check on every rising edge of clk, reset included.
`define S3X_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed during or after reset");

`endif

// ----- rtl/s3x_pkg.sv -----
package s3x_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = 10;
    localparam int BLK_W      = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int TDATA_W    = 96;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd320;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd200;

    typedef logic [PIX_W-1:0] pix_t;

    typedef logic [8:0][PIX_W-1:0] block_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    function automatic block_t scale3x_block(
        input pix_t a, input pix_t b, input pix_t c,
        input pix_t d, input pix_t e, input pix_t f,
        input pix_t g, input pix_t h, input pix_t i
    );
        block_t s;
        s = {9{e}};
        if (b != h && d != f)
        begin
            s[0] = (d == b) ? d : e;
            s[1] = ((d == b && e != c) || (b == f && e != a)) ? b : e;
            s[2] = (b == f) ? f : e;
            s[3] = ((d == b && e != g) || (d == h && e != a)) ? d : e;
            s[5] = ((b == f && e != i) || (h == f && e != c)) ? f : e;
            s[6] = (d == h) ? d : e;
            s[7] = ((d == h && e != i) || (h == f && e != g)) ? h : e;
            s[8] = (h == f) ? f : e;
        end
        return s;
    endfunction

endpackage

// ----- rtl/scale3x_pixel_art_upscaler_unit.sv -----
// Channel   Dir  Width  Request carries
// s_*       in   8      pixel, raster order
// m_*       out  96     one 3x3 Scale3x block with its source row and column
// apb       in   3/32   frame_width at 0x0, frame_height at 0x4
//
// One pixel per cycle while m_tready is high and a pixel causes at most one block;
// a pixel that causes n blocks (up to four, at row ends and in the last row) holds
// s_tready low while the emit stage walks them out.
// An input request passes the line buffer read, the emit stage and the result
// register in that order before its first block appears.
// Each line buffer takes one read and one write per cycle. rst_n presets frame size,
// clears counters, valid flags and window columns, not data or line buffers.
// m_tready low stalls the result register, then the emit stage, then s_tready.
module scale3x_pixel_art_upscaler_unit
    import s3x_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PIX_W-1:0]    s_tdata,   // [7:0] pixel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // sub_top_left..sub_bottom_right [71:0],
                                           // block_row [81:72], block_col [91:82]
    output logic                m_tlast,   // last_of_run
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > CFG_W) ? WW : CFG_W;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    w_clamp;
    logic [CW-1:0]    w_last;
    logic [CFG_W-1:0] h_clamp;
    logic [ROW_W-1:0] h_last;

    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic             s_acc;
    logic             cur_last_col;
    logic             cur_last_row;

    pix_t             upper_line_mem  [MAX_WIDTH];
    pix_t             middle_line_mem [MAX_WIDTH];
    pix_t             upper_rd_reg;
    pix_t             middle_rd_reg;

    logic             s1_valid_reg;
    pix_t             s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    logic             s1_emit;
    logic             s1_go;
    column_t          new_col;
    pix_t             upper_wr;

    column_t          win_mid_reg;
    column_t          win_right_reg;

    logic             s2_valid_reg;
    column_t          s2_left_reg;
    column_t          s2_mid_reg;
    column_t          s2_right_reg;
    logic [CW-1:0]    s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic             s2_last_col_reg;
    logic             s2_last_row_reg;
    logic             s2_lower_reg;
    logic             s2_shift_reg;
    logic             s2_done;
    logic             s2_free;
    logic             s2_issue;

    column_t          col_a;
    column_t          col_b;
    column_t          col_c;
    pix_t             a_top, a_mid, a_bot;
    pix_t             b_top, b_mid, b_bot;
    pix_t             c_top, c_mid, c_bot;
    block_t           blk;
    logic [BLK_W-1:0] blk_row;
    logic [BLK_W-1:0] blk_col;

    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic               out_last_reg;
    logic               out_free;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp frame size
    always_comb
    begin
        fw_ext = EW'(frame_width_reg);
        if (fw_ext < EW'(2))
            w_clamp = EW'(2);
        else if (fw_ext > EW'(MAX_WIDTH))
            w_clamp = EW'(MAX_WIDTH);
        else
            w_clamp = fw_ext;
        w_last = CW'(w_clamp - EW'(1));

        if (frame_height_reg < CFG_W'(2))
            h_clamp = CFG_W'(2);
        else if (frame_height_reg > CFG_W'(MAX_HEIGHT))
            h_clamp = CFG_W'(MAX_HEIGHT);
        else
            h_clamp = frame_height_reg;
        h_last = ROW_W'(h_clamp - CFG_W'(1));
    end

    // position counters
    assign s_acc        = s_tvalid && s_tready;
    assign cur_last_col = (col_count_reg == w_last);
    assign cur_last_row = (row_count_reg == h_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (s_acc)
        begin
            if (cur_last_col)
            begin
                col_count_reg <= '0;
                row_count_reg <= cur_last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // line buffers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            upper_rd_reg  <= upper_line_mem[col_count_reg];
            middle_rd_reg <= middle_line_mem[col_count_reg];
            middle_line_mem[col_count_reg] <= s_tdata;
        end
        if (s1_go)
            upper_line_mem[s1_col_reg] <= upper_wr;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_pix_reg      <= s_tdata;
            s1_col_reg      <= col_count_reg;
            s1_row_reg      <= row_count_reg;
            s1_last_col_reg <= cur_last_col;
            s1_last_row_reg <= cur_last_row;
        end
    end

    always_comb
    begin
        if (s1_row_reg == '0)
        begin
            new_col.top = s1_pix_reg;
            new_col.mid = s1_pix_reg;
        end
        else
        begin
            new_col.top = upper_rd_reg;
            new_col.mid = middle_rd_reg;
        end
        new_col.bot = s1_pix_reg;
        upper_wr    = new_col.mid;
    end

    assign s1_emit  = (s1_row_reg != '0) && (s1_col_reg != '0);
    assign s1_go    = s1_valid_reg && (!s1_emit || s2_free);
    assign s_tready = !s1_valid_reg || s1_go;

    // window columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_mid_reg   <= '0;
            win_right_reg <= '0;
        end
        else if (s1_go)
        begin
            win_mid_reg   <= (s1_col_reg == '0) ? new_col : win_right_reg;
            win_right_reg <= new_col;
        end
    end

    // emit stage
    always_comb
    begin
        s2_done  = (!s2_last_row_reg || s2_lower_reg) && (!s2_last_col_reg || s2_shift_reg);
        s2_issue = s2_valid_reg && out_free;
        s2_free  = !s2_valid_reg || (out_free && s2_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_lower_reg <= 1'b0;
            s2_shift_reg <= 1'b0;
        end
        else if (s1_go && s1_emit)
        begin
            s2_valid_reg <= 1'b1;
            s2_lower_reg <= 1'b0;
            s2_shift_reg <= 1'b0;
        end
        else if (s2_issue)
        begin
            if (s2_done)
            begin
                s2_valid_reg <= 1'b0;
            end
            else if (s2_last_row_reg && !s2_lower_reg)
            begin
                s2_lower_reg <= 1'b1;
            end
            else
            begin
                s2_shift_reg <= 1'b1;
                s2_lower_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            s2_left_reg     <= win_mid_reg;
            s2_mid_reg      <= win_right_reg;
            s2_right_reg    <= new_col;
            s2_col_reg      <= s1_col_reg;
            s2_row_reg      <= s1_row_reg;
            s2_last_col_reg <= s1_last_col_reg;
            s2_last_row_reg <= s1_last_row_reg;
        end
    end

    always_comb
    begin
        col_a = s2_shift_reg ? s2_mid_reg   : s2_left_reg;
        col_b = s2_shift_reg ? s2_right_reg : s2_mid_reg;
        col_c = s2_right_reg;

        a_top = s2_lower_reg ? col_a.mid : col_a.top;
        a_mid = s2_lower_reg ? col_a.bot : col_a.mid;
        a_bot = col_a.bot;
        b_top = s2_lower_reg ? col_b.mid : col_b.top;
        b_mid = s2_lower_reg ? col_b.bot : col_b.mid;
        b_bot = col_b.bot;
        c_top = s2_lower_reg ? col_c.mid : col_c.top;
        c_mid = s2_lower_reg ? col_c.bot : col_c.mid;
        c_bot = col_c.bot;

        blk = scale3x_block(a_top, b_top, c_top,
                            a_mid, b_mid, c_mid,
                            a_bot, b_bot, c_bot);

        blk_row = s2_lower_reg ? BLK_W'(s2_row_reg) : BLK_W'(s2_row_reg - ROW_W'(1));
        blk_col = s2_shift_reg ? BLK_W'(s2_col_reg) : BLK_W'(s2_col_reg - CW'(1));
    end

    // result register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_issue)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_issue)
        begin
            out_data_reg <= {4'b0000, blk_col, blk_row, blk};
            out_last_reg <= s2_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/s3x_checker.sv -----
`include "scale3x_pixel_art_upscaler_unit_defines.svh"

module s3x_checker
    import s3x_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [TDATA_W-1:0]  m_tdata,
    input logic                m_tlast,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [APB_AW-1:0]   paddr,
    input logic [APB_DW-1:0]   pwdata,
    input logic [APB_DW-1:0]   prdata,
    input logic                pready
);

    `S3X_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `S3X_ASSERT(a_run_continues, m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    `S3X_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && paddr[2] == 1'b0 |=> paddr[2] != 1'b0 || prdata[10:0] == $past(pwdata[10:0]))
    `S3X_ASSERT_RST(a_reset_quiet, !rst_n |=> !m_tvalid && pready)

endmodule

bind scale3x_pixel_art_upscaler_unit s3x_checker u_s3x_checker (.*);
